>>> design/lgu_pkg.sv
// Shared types and constants of the laser occupancy grid update block.
// Holds the sequencer state type, status and command codes, register indexes
// and the CORDIC arctangent table. Depends on nothing.
package lgu_pkg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_ANGLE,
        S_CORDIC,
        S_ROUND,
        S_END_X,
        S_END_Y,
        S_END_CHK,
        S_PAD,
        S_RAY_X,
        S_RAY_Y,
        S_RAY_W,
        S_QUERY,
        S_QREAD,
        S_RESULT
    } state_t;

    // Result status codes
    localparam logic [1:0] ST_OBSTACLE   = 2'd0;
    localparam logic [1:0] ST_NO_HIT     = 2'd1;
    localparam logic [1:0] ST_OUT_OF_MAP = 2'd2;
    localparam logic [1:0] ST_QUERY      = 2'd3;

    // Input commands
    localparam logic CMD_BEAM  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_BEAM_COUNT = 2'd0;
    localparam logic [1:0] CFG_MAX_RANGE  = 2'd1;
    localparam logic [1:0] CFG_PADDING    = 2'd2;
    localparam logic [1:0] CFG_OUT_MARGIN = 2'd3;

    // Angle offset: (half degrees plus two turns) scaled to the angle unit,
    // plus 360, over 720. Since 720 = 45 << 4, drop the low 4 bits first
    // (360 >> 4 floors to 22), then divide by 45 with a reciprocal multiply.
    localparam logic [11:0] HALF_DEG_BIAS = 12'd1440;
    localparam int          DEG_DIV_SHIFT = 4;
    localparam int          DEG_DIV_ODD   = 45;
    localparam int          DEG_ROUND_SH  = 22;

    // Rotation CORDIC in Q30, gain prescaled
    localparam int                 CORDIC_STEPS = 30;
    localparam logic signed [32:0] CORDIC_GAIN  = 33'sd652032874;

    // atan(2^-i) in 2^-32 turn units
    function automatic logic [31:0] atan_turn32(input logic [4:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                5'd0:  r = 32'h20000000;
                5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B;
                5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;
                5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;
                5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;
                5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA;
                5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;
                5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C;
                5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3;
                5'd23: r = 32'h00000051;
                5'd24: r = 32'h00000029;
                5'd25: r = 32'h00000014;
                5'd26: r = 32'h0000000A;
                5'd27: r = 32'h00000005;
                5'd28: r = 32'h00000003;
                5'd29: r = 32'h00000001;
                default: r = 32'h00000000;
            endcase
            return r;
        end
    endfunction

    // Round a Q30 value half up to Q16 and clamp to [-1, 1]
    function automatic logic signed [17:0] to_q16(input logic signed [33:0] v);
        logic signed [33:0] r;
        begin
            r = (v + 34'sd8192) >>> 14;
            priority if (r > 34'sd65536)
                return 18'sd65536;
            else if (r < -34'sd65536)
                return -18'sd65536;
            else
                return r[17:0];
        end
    endfunction

endpackage

>>> design/lgu_ram.sv
// Generic single-port RAM with registered read data.
// Used for the cell flag planes; depends on nothing.
module lgu_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read at one address
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/laser_occupancy_grid_update.sv
// Beam item steps: accept, one reciprocal divide, angle fold, 30 CORDIC steps, rounding,
// three endpoint steps, ray setup, result; plus (2*padding_cells + 1)^2 obstacle writes
// when the endpoint is an obstacle, and a walk over range/2^FRAC_BITS + 1 ray cells.
// Query item: accept, grid read, flag capture, result. One item at a time; the shared
// multiplier and the single RAM port set the per-cell cost. After reset a clearing pass
// zeroes all 4^clog2(GRID_SIZE) cells (65536 at the default size) before the first word is accepted.
// Uses lgu_pkg and lgu_ram.
module laser_occupancy_grid_update #(
    parameter int GRID_SIZE  = 256,
    parameter int FRAC_BITS  = 8,
    parameter int ANGLE_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  logic [15:0]        robot_x,
    input  logic [15:0]        robot_y,
    input  logic [15:0]        heading,
    input  logic [9:0]         beam_index,
    input  logic [15:0]        range_dist,
    input  logic signed [9:0]  cell_x,
    input  logic signed [9:0]  cell_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic               obstacle,
    output logic               seen
);

    localparam int IB    = $clog2(GRID_SIZE);
    localparam int AW    = 2 * IB;
    localparam int DEPTH = 1 << AW;
    localparam int MW    = 12 + ANGLE_BITS - lgu_pkg::DEG_DIV_SHIFT;
    localparam int DK    = MW + 6;
    localparam logic [MW:0] RECIP = (MW+1)'(((64'd1 << DK)
                                  + 64'(lgu_pkg::DEG_DIV_ODD - 1))
                                  / 64'(lgu_pkg::DEG_DIV_ODD));
    localparam int PW    = 26;
    localparam logic signed [PW-1:0] ONE    = PW'(1 << FRAC_BITS);
    localparam logic signed [PW-1:0] EXTENT = PW'(GRID_SIZE << FRAC_BITS);
    localparam logic signed [16:0]   ONE_D  = 17'(1 << FRAC_BITS);

    // Configuration
    logic [9:0]  beam_count_reg;
    logic [15:0] max_range_reg;
    logic [3:0]  padding_reg;
    logic [15:0] out_margin_reg;

    // Sequencer
    lgu_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   clr_reg;
    logic [5:0]      step_reg;

    // Item payload
    logic                  cmd_reg;
    logic [15:0]           rx_reg, ry_reg, dist_reg;
    logic signed [9:0]     qx_reg, qy_reg;
    logic [ANGLE_BITS-1:0] hscaled_reg;

    // Datapath
    logic [MW-1:0]      div_num_reg;
    logic [ANGLE_BITS-1:0] offset_reg;
    logic signed [32:0] cx_reg, cy_reg, cz_reg;
    logic [1:0]         quad_reg;
    logic signed [17:0] c_reg, s_reg;
    logic signed [34:0] prod_reg;
    logic signed [PW-1:0] ex_reg, ey_reg, px_reg, pad_vx_reg, pad_vy_reg;
    logic signed [16:0] d_reg;
    logic [4:0]         pad_i_reg, pad_j_reg;
    logic [1:0]         res_status_reg;
    logic               res_ob_reg, res_sn_reg;

    // Output word
    logic       out_valid_reg;
    logic [1:0] status_reg;
    logic       obstacle_reg, seen_reg;

    // Combinational helpers
    logic               accept;
    logic [11:0]        half_deg;
    logic [15+ANGLE_BITS:0] heading_wide;
    logic [2*MW:0]      div_prod;
    logic [ANGLE_BITS-1:0] angle;
    logic [31:0]        a32, a32_bias, z32;
    logic signed [32:0] xs, ys, atan_v;
    logic signed [33:0] rot_c, rot_s;
    logic signed [17:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [34:0] mul_p;
    logic signed [34:0] prod_adj;
    logic signed [18:0] prod_tr;
    logic signed [PW-1:0] pos_x, pos_y, margin, pad_ofs;
    logic signed [16:0] d_dec;
    logic               out_of_map;
    logic signed [PW-1:0] mark_vx, mark_vy, adj_x, adj_y, cell_cx, cell_cy;
    logic               mark_in_grid, query_in_grid;
    logic [4:0]         pad_lim;
    logic [AW-1:0]      ram_addr;
    logic               obs_we, seen_we, ram_wdata;
    logic               obs_rdata, seen_rdata;

    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == lgu_pkg::S_IDLE);

    // Angle offset numerator and heading scaling
    assign half_deg = {1'b0, beam_index, 1'b0} + lgu_pkg::HALF_DEG_BIAS
                    - {2'b00, beam_count_reg};
    assign heading_wide = {heading, {ANGLE_BITS{1'b0}}};

    // Divide by 45 through the reciprocal
    assign div_prod = div_num_reg * RECIP;

    // Quadrant fold
    assign angle    = hscaled_reg + offset_reg;
    assign a32      = {angle, {(32-ANGLE_BITS){1'b0}}};
    assign a32_bias = a32 + 32'h2000_0000;
    assign z32      = a32 - {a32_bias[31:30], 30'd0};

    // CORDIC step operands
    assign xs     = cx_reg >>> step_reg[4:0];
    assign ys     = cy_reg >>> step_reg[4:0];
    assign atan_v = $signed({1'b0, lgu_pkg::atan_turn32(step_reg[4:0])});

    // Restore quadrant
    always_comb
    begin
        unique case (quad_reg)
            2'd0:
            begin
                rot_c = 34'(cx_reg);
                rot_s = 34'(cy_reg);
            end
            2'd1:
            begin
                rot_c = -34'(cy_reg);
                rot_s = 34'(cx_reg);
            end
            2'd2:
            begin
                rot_c = -34'(cx_reg);
                rot_s = -34'(cy_reg);
            end
            default:
            begin
                rot_c = 34'(cy_reg);
                rot_s = -34'(cx_reg);
            end
        endcase
    end

    // Shared multiplier operand select
    assign d_dec = d_reg - ONE_D;
    always_comb
    begin
        mul_a = c_reg;
        mul_b = d_reg;
        unique case (state_reg)
            lgu_pkg::S_END_X: mul_b = $signed({1'b0, dist_reg});
            lgu_pkg::S_END_Y:
            begin
                mul_a = s_reg;
                mul_b = $signed({1'b0, dist_reg});
            end
            lgu_pkg::S_RAY_Y: mul_a = s_reg;
            lgu_pkg::S_RAY_W: mul_b = d_dec;
            default: ;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Truncate product / 65536 toward zero and add robot position
    assign prod_adj = prod_reg[34] ? (prod_reg + 35'sd65535) : prod_reg;
    assign prod_tr  = 19'(prod_adj >>> 16);
    assign pos_x = $signed({{(PW-16){1'b0}}, rx_reg}) + PW'(prod_tr);
    assign pos_y = $signed({{(PW-16){1'b0}}, ry_reg}) + PW'(prod_tr);

    // Out of map test on the endpoint
    assign margin  = $signed({{(PW-16){1'b0}}, out_margin_reg});
    assign out_of_map = (ex_reg < -margin) || (ex_reg > EXTENT + margin)
                     || (pos_y < -margin) || (pos_y > EXTENT + margin);
    assign pad_ofs = $signed({{(PW-4){1'b0}}, padding_reg}) <<< FRAC_BITS;
    assign pad_lim = {padding_reg, 1'b0};

    // Cell index of the point being marked, truncated toward zero
    assign mark_vx = (state_reg == lgu_pkg::S_PAD) ? pad_vx_reg : px_reg;
    assign mark_vy = (state_reg == lgu_pkg::S_PAD) ? pad_vy_reg : pos_y;
    assign adj_x   = mark_vx[PW-1] ? (mark_vx + ONE - PW'(1)) : mark_vx;
    assign adj_y   = mark_vy[PW-1] ? (mark_vy + ONE - PW'(1)) : mark_vy;
    assign cell_cx = adj_x >>> FRAC_BITS;
    assign cell_cy = adj_y >>> FRAC_BITS;
    assign mark_in_grid = !cell_cx[PW-1] && (cell_cx < PW'(GRID_SIZE))
                       && !cell_cy[PW-1] && (cell_cy < PW'(GRID_SIZE));
    assign query_in_grid = !qx_reg[9] && (int'(qx_reg[8:0]) < GRID_SIZE)
                        && !qy_reg[9] && (int'(qy_reg[8:0]) < GRID_SIZE);

    // Grid port: clearing pass, query read or flag write
    always_comb
    begin
        obs_we    = 1'b0;
        seen_we   = 1'b0;
        ram_wdata = 1'b1;
        ram_addr  = {cell_cx[IB-1:0], cell_cy[IB-1:0]};
        unique case (state_reg)
            lgu_pkg::S_CLEAR:
            begin
                obs_we    = 1'b1;
                seen_we   = 1'b1;
                ram_wdata = 1'b0;
                ram_addr  = clr_reg;
            end
            lgu_pkg::S_QUERY: ram_addr = {qx_reg[IB-1:0], qy_reg[IB-1:0]};
            lgu_pkg::S_PAD:   obs_we   = mark_in_grid;
            lgu_pkg::S_RAY_W: seen_we  = mark_in_grid;
            default: ;
        endcase
    end

    lgu_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_obs_ram (
        .clk   (clk),
        .we    (obs_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (obs_rdata)
    );

    lgu_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_seen_ram (
        .clk   (clk),
        .we    (seen_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (seen_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lgu_pkg::S_CLEAR:
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = lgu_pkg::S_IDLE;
            lgu_pkg::S_IDLE:
                if (accept)
                    state_next = (command == lgu_pkg::CMD_QUERY) ? lgu_pkg::S_QUERY
                                                                 : lgu_pkg::S_DIV;
            lgu_pkg::S_DIV:    state_next = lgu_pkg::S_ANGLE;
            lgu_pkg::S_ANGLE:  state_next = lgu_pkg::S_CORDIC;
            lgu_pkg::S_CORDIC:
                if (step_reg == 6'(lgu_pkg::CORDIC_STEPS - 1))
                    state_next = lgu_pkg::S_ROUND;
            lgu_pkg::S_ROUND:  state_next = lgu_pkg::S_END_X;
            lgu_pkg::S_END_X:  state_next = lgu_pkg::S_END_Y;
            lgu_pkg::S_END_Y:  state_next = lgu_pkg::S_END_CHK;
            lgu_pkg::S_END_CHK:
                if (!out_of_map && (dist_reg < max_range_reg))
                    state_next = lgu_pkg::S_PAD;
                else
                    state_next = lgu_pkg::S_RAY_X;
            lgu_pkg::S_PAD:
                if (pad_i_reg == pad_lim && pad_j_reg == pad_lim)
                    state_next = lgu_pkg::S_RAY_X;
            lgu_pkg::S_RAY_X:  state_next = lgu_pkg::S_RAY_Y;
            lgu_pkg::S_RAY_Y:  state_next = lgu_pkg::S_RAY_W;
            lgu_pkg::S_RAY_W:
                state_next = d_dec[16] ? lgu_pkg::S_RESULT : lgu_pkg::S_RAY_Y;
            lgu_pkg::S_QUERY:  state_next = lgu_pkg::S_QREAD;
            lgu_pkg::S_QREAD:  state_next = lgu_pkg::S_RESULT;
            lgu_pkg::S_RESULT:
                if (!out_valid_reg || out_ready)
                    state_next = lgu_pkg::S_IDLE;
            default: state_next = lgu_pkg::S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lgu_pkg::S_CLEAR;
            clr_reg        <= '0;
            beam_count_reg <= 10'd361;
            max_range_reg  <= 16'd20480;
            padding_reg    <= 4'd2;
            out_margin_reg <= 16'd1280;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == lgu_pkg::S_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lgu_pkg::CFG_BEAM_COUNT: beam_count_reg <= cfg_wdata[9:0];
                    lgu_pkg::CFG_MAX_RANGE:  max_range_reg  <= cfg_wdata;
                    lgu_pkg::CFG_PADDING:    padding_reg    <= cfg_wdata[3:0];
                    default:                 out_margin_reg <= cfg_wdata;
                endcase
            end
            // Hold the output word until taken
            if (state_reg == lgu_pkg::S_RESULT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            lgu_pkg::S_IDLE:
                if (accept)
                begin
                    cmd_reg        <= command;
                    rx_reg         <= robot_x;
                    ry_reg         <= robot_y;
                    dist_reg       <= range_dist;
                    qx_reg         <= cell_x;
                    qy_reg         <= cell_y;
                    hscaled_reg    <= heading_wide[15+ANGLE_BITS:16];
                    div_num_reg    <= {half_deg,
                                       {(ANGLE_BITS-lgu_pkg::DEG_DIV_SHIFT){1'b0}}}
                                    + MW'(lgu_pkg::DEG_ROUND_SH);
                    step_reg       <= '0;
                    res_ob_reg     <= 1'b0;
                    res_sn_reg     <= 1'b0;
                end
            lgu_pkg::S_DIV:
            begin
                offset_reg <= div_prod[DK +: ANGLE_BITS];
            end
            lgu_pkg::S_ANGLE:
            begin
                quad_reg <= a32_bias[31:30];
                cz_reg   <= $signed({z32[31], z32});
                cx_reg   <= lgu_pkg::CORDIC_GAIN;
                cy_reg   <= '0;
                step_reg <= '0;
            end
            lgu_pkg::S_CORDIC:
            begin
                // Rotate toward zero residual angle
                if (!cz_reg[32])
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - atan_v;
                end
                else
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + atan_v;
                end
                step_reg <= step_reg + 6'd1;
            end
            lgu_pkg::S_ROUND:
            begin
                c_reg <= lgu_pkg::to_q16(rot_c);
                s_reg <= lgu_pkg::to_q16(rot_s);
            end
            lgu_pkg::S_END_X: prod_reg <= mul_p;
            lgu_pkg::S_END_Y:
            begin
                ex_reg   <= pos_x;
                prod_reg <= mul_p;
            end
            lgu_pkg::S_END_CHK:
            begin
                ey_reg     <= pos_y;
                d_reg      <= $signed({1'b0, dist_reg});
                pad_vx_reg <= ex_reg - pad_ofs;
                pad_vy_reg <= pos_y - pad_ofs;
                pad_i_reg  <= '0;
                pad_j_reg  <= '0;
                priority if (out_of_map)
                    res_status_reg <= lgu_pkg::ST_OUT_OF_MAP;
                else if (dist_reg < max_range_reg)
                    res_status_reg <= lgu_pkg::ST_OBSTACLE;
                else
                    res_status_reg <= lgu_pkg::ST_NO_HIT;
            end
            lgu_pkg::S_PAD:
            begin
                // Walk the padded square, rows inner
                if (pad_j_reg == pad_lim)
                begin
                    pad_j_reg  <= '0;
                    pad_vy_reg <= ey_reg - pad_ofs;
                    pad_i_reg  <= pad_i_reg + 5'd1;
                    pad_vx_reg <= pad_vx_reg + ONE;
                end
                else
                begin
                    pad_j_reg  <= pad_j_reg + 5'd1;
                    pad_vy_reg <= pad_vy_reg + ONE;
                end
            end
            lgu_pkg::S_RAY_X: prod_reg <= mul_p;
            lgu_pkg::S_RAY_Y:
            begin
                px_reg   <= pos_x;
                prod_reg <= mul_p;
            end
            lgu_pkg::S_RAY_W:
            begin
                d_reg    <= d_dec;
                prod_reg <= mul_p;
            end
            lgu_pkg::S_QREAD:
            begin
                res_status_reg <= lgu_pkg::ST_QUERY;
                res_ob_reg     <= query_in_grid ? obs_rdata : 1'b1;
                res_sn_reg     <= query_in_grid ? seen_rdata : 1'b1;
            end
            lgu_pkg::S_RESULT:
                if (!out_valid_reg || out_ready)
                begin
                    status_reg   <= res_status_reg;
                    obstacle_reg <= res_ob_reg;
                    seen_reg     <= res_sn_reg;
                end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign obstacle  = obstacle_reg;
    assign seen      = seen_reg;

    // Beam words carry no cell flags
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != lgu_pkg::ST_QUERY |-> !obstacle && !seen)
        else $error("beam word carries cell flags");

    // Grid is only written by the clearing pass, padding or ray walk
    assert property (@(posedge clk) disable iff (!rst_n)
        (obs_we || seen_we) |-> state_reg == lgu_pkg::S_CLEAR
            || state_reg == lgu_pkg::S_PAD || state_reg == lgu_pkg::S_RAY_W)
        else $error("grid write outside a marking step");

    // Query and beam paths stay apart
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lgu_pkg::S_QUERY |-> cmd_reg == lgu_pkg::CMD_QUERY)
        else $error("query step on a beam word");

    // Ray walk ends once the distance has gone negative
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lgu_pkg::S_RAY_W && d_dec[16] |=> state_reg == lgu_pkg::S_RESULT)
        else $error("ray walk overran");

endmodule
